### rtl/mtt_pkg.sv
// Shared types and constants of the message text tokenizer.
package mtt_pkg;

    // Width of the signed bracket nesting count
    localparam int NEST_BITS = 8;
    localparam logic signed [NEST_BITS-1:0] NEST_MAX = {1'b0, {(NEST_BITS-1){1'b1}}};
    localparam logic signed [NEST_BITS-1:0] NEST_MIN = {1'b1, {(NEST_BITS-1){1'b0}}};

    // Depths of the command queue and the result queue
    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
    localparam int RES_Q_DEPTH = 2;
    localparam int RES_Q_PTR_W = $clog2(RES_Q_DEPTH);

    // Characters of interest
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_RBR    = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // Class of a token's first character
    localparam logic [1:0] CLS_NUM  = 2'd0;
    localparam logic [1:0] CLS_LIST = 2'd2;
    localparam logic [1:0] CLS_STR  = 2'd3;

    // Token kinds
    localparam logic [1:0] KIND_INT    = 2'd0;
    localparam logic [1:0] KIND_DOUBLE = 2'd1;

    // Classified character handed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       blank;
        logic       quote;
        logic       lbr;
        logic       rbr;
        logic       bslash;
        logic       dot;
        logic [1:0] cls;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic       keep_char;
        logic [7:0] out_char;
        logic       token_done;
        logic [1:0] token_kind;
        logic       dropped;
    } res_t;

endpackage

### rtl/mtt_front.sv
// Front end: classifies each character and queues it for the back end.
module mtt_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    ch,
    input  logic          line_end,
    input  logic          push,
    output logic          full,
    output logic          cmd_valid,
    output mtt_pkg::cmd_t cmd,
    input  logic          cmd_take
);

    mtt_pkg::cmd_t                   cmd_mem_reg [mtt_pkg::CMD_Q_DEPTH];
    logic [mtt_pkg::CMD_Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mtt_pkg::CMD_Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mtt_pkg::CMD_Q_PTR_W:0]   cnt_reg, cnt_next;
    mtt_pkg::cmd_t                   cls_cmd;
    logic [7:0]                      c;
    logic                            wr_en;
    logic                            rd_en;

    // Classify the incoming character; a line end stands for a space
    always_comb
    begin
        c               = line_end ? mtt_pkg::CH_SPACE : ch;
        cls_cmd.ch      = c;
        cls_cmd.last    = line_end;
        cls_cmd.blank   = (c == mtt_pkg::CH_SPACE) || (c == mtt_pkg::CH_TAB);
        cls_cmd.quote   = (c == mtt_pkg::CH_QUOTE);
        cls_cmd.lbr     = (c == mtt_pkg::CH_LBR);
        cls_cmd.rbr     = (c == mtt_pkg::CH_RBR);
        cls_cmd.bslash  = (c == mtt_pkg::CH_BSLASH);
        cls_cmd.dot     = (c == mtt_pkg::CH_DOT);
        if ((c >= mtt_pkg::CH_ZERO && c <= mtt_pkg::CH_NINE) || c == mtt_pkg::CH_PLUS ||
            c == mtt_pkg::CH_MINUS || c == mtt_pkg::CH_DOT)
        begin
            cls_cmd.cls = mtt_pkg::CLS_NUM;
        end
        else if (c == mtt_pkg::CH_LBR)
        begin
            cls_cmd.cls = mtt_pkg::CLS_LIST;
        end
        else
        begin
            cls_cmd.cls = mtt_pkg::CLS_STR;
        end
    end

    // Queue handshake
    assign full      = (cnt_reg == (mtt_pkg::CMD_Q_PTR_W+1)'(mtt_pkg::CMD_Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = cmd_mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the classified transaction
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cmd_mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

### rtl/mtt_back.sv
// Back end: runs the tokenizer state and queues one result per character.
module mtt_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  mtt_pkg::cmd_t cmd,
    output logic          cmd_take,
    input  logic          pop,
    output logic          empty,
    output mtt_pkg::res_t res
);

    logic                                  esc_reg, esc_next;
    logic                                  inq_reg, inq_next;
    logic                                  begun_reg, begun_next;
    logic signed [mtt_pkg::NEST_BITS-1:0]  nest_reg, nest_next;
    logic [1:0]                            fc_reg, fc_next;
    logic                                  dot_reg, dot_next;
    mtt_pkg::res_t                         step_res;

    mtt_pkg::res_t                         res_mem_reg [mtt_pkg::RES_Q_DEPTH];
    logic [mtt_pkg::RES_Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mtt_pkg::RES_Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mtt_pkg::RES_Q_PTR_W:0]         cnt_reg, cnt_next;
    logic                                  rd_en;
    logic                                  room;

    // Take a command when the result queue has room, counting a pop this cycle
    assign empty    = (cnt_reg == '0);
    assign rd_en    = pop && !empty;
    assign room     = (cnt_reg != (mtt_pkg::RES_Q_PTR_W+1)'(mtt_pkg::RES_Q_DEPTH)) || rd_en;
    assign cmd_take = cmd_valid && room;
    assign res      = res_mem_reg[rd_ptr_reg];

    // Tokenizer step for one character
    always_comb
    begin
        esc_next   = esc_reg;
        inq_next   = inq_reg;
        begun_next = begun_reg;
        nest_next  = nest_reg;
        fc_next    = fc_reg;
        dot_next   = dot_reg;
        step_res   = '0;

        if (esc_reg)
        begin
            // Escaped character is taken literally
            step_res.keep_char = 1'b1;
            step_res.out_char  = cmd.ch;
            dot_next           = dot_reg || cmd.dot;
            esc_next           = 1'b0;
        end
        else
        begin
            // Open a token at its first non-blank character
            if (!begun_reg && !cmd.blank)
            begin
                begun_next = 1'b1;
                fc_next    = cmd.cls;
                dot_next   = 1'b0;
            end
            if (begun_next)
            begin
                if (cmd.quote)
                begin
                    inq_next = !inq_reg;
                end
                if (!inq_next)
                begin
                    if (cmd.lbr && nest_reg != mtt_pkg::NEST_MAX)
                    begin
                        nest_next = nest_reg + 1'b1;
                    end
                    if (cmd.rbr && nest_reg != mtt_pkg::NEST_MIN)
                    begin
                        nest_next = nest_reg - 1'b1;
                    end
                end
                if (cmd.bslash)
                begin
                    esc_next           = 1'b1;
                    step_res.keep_char = 1'b1;
                    step_res.out_char  = cmd.ch;
                end
                else if (!inq_next && cmd.blank && nest_next == '0)
                begin
                    // Close the token and report its kind
                    step_res.token_done = 1'b1;
                    if (fc_next == mtt_pkg::CLS_NUM)
                    begin
                        step_res.token_kind = dot_next ? mtt_pkg::KIND_DOUBLE
                                                       : mtt_pkg::KIND_INT;
                    end
                    else
                    begin
                        step_res.token_kind = fc_next;
                    end
                    begun_next = 1'b0;
                    fc_next    = mtt_pkg::CLS_NUM;
                    dot_next   = 1'b0;
                end
                else
                begin
                    step_res.keep_char = 1'b1;
                    step_res.out_char  = cmd.ch;
                    dot_next           = dot_next || cmd.dot;
                end
            end
        end

        // Line end: flag an open token as dropped, then clear the state
        if (cmd.last)
        begin
            step_res.dropped = begun_next;
            esc_next         = 1'b0;
            inq_next         = 1'b0;
            begun_next       = 1'b0;
            nest_next        = '0;
            fc_next          = mtt_pkg::CLS_NUM;
            dot_next         = 1'b0;
        end
    end

    // Advance result queue pointers and count
    always_comb
    begin
        wr_ptr_next = cmd_take ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (cmd_take && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !cmd_take)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            inq_reg    <= 1'b0;
            begun_reg  <= 1'b0;
            nest_reg   <= '0;
            fc_reg     <= mtt_pkg::CLS_NUM;
            dot_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                esc_reg   <= esc_next;
                inq_reg   <= inq_next;
                begun_reg <= begun_next;
                nest_reg  <= nest_next;
                fc_reg    <= fc_next;
                dot_reg   <= dot_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            res_mem_reg[wr_ptr_reg] <= step_res;
        end
    end

endmodule

### rtl/message_text_tokenizer_top.sv
// Top level of the message text tokenizer.
// Takes one character of a text line per transaction and returns one result per
// character: whether it is kept in the current token, whether a token ends there and
// its kind, and on a line end whether an unfinished token was dropped. It sustains
// one character per clock cycle while results are popped; the combinational tokenizer
// step in the back end is fed from a four-entry command queue and writes a two-entry
// result queue, so an accepted character is stored in the command queue and its result
// in the result queue before it shows, and a stalled pop backs up into full.
module message_text_tokenizer_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       line_end,
    input  logic       pop,
    output logic       empty,
    output logic       keep_char,
    output logic [7:0] out_char,
    output logic       token_done,
    output logic [1:0] token_kind,
    output logic       dropped
);

    logic          cmd_valid;
    logic          cmd_take;
    mtt_pkg::cmd_t cmd;
    mtt_pkg::res_t res;

    mtt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .line_end  (line_end),
        .push      (push),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    mtt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign keep_char  = res.keep_char;
    assign out_char   = res.out_char;
    assign token_done = res.token_done;
    assign token_kind = res.token_kind;
    assign dropped    = res.dropped;

endmodule

### rtl/mtt_checker.sv
// Port-level assertions of the message text tokenizer and their bind.
module mtt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] ch,
    input logic       line_end,
    input logic       pop,
    input logic       empty,
    input logic       keep_char,
    input logic [7:0] out_char,
    input logic       token_done,
    input logic [1:0] token_kind,
    input logic       dropped
);

    // Both queues come out of reset empty
    assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not empty in reset");

    // A character is never both kept and the end of a token
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(keep_char && token_done))
        else $error("kept character also ends a token");

    // A dropped line end never reports a finished token
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && dropped |-> !token_done)
        else $error("dropped and token_done together");

    // Unused result fields read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (keep_char || out_char == 8'd0) && (token_done || token_kind == 2'd0))
        else $error("stray value in unused result field");

    // With the result queue empty and room in the command queue, an accepted character shows up later
    assert property (@(posedge clk) disable iff (!rst_n)
        empty && !full && push |=> ##1 !empty)
        else $error("accepted character produced no result");

endmodule

bind message_text_tokenizer_top mtt_checker u_mtt_checker (.*);
